// ===== design/exp3_pkg.sv =====
// ----------------------------------------------------------------------------
// exp3 bandit package
// shared types, codes, default sizes and the exp(-2^(k-16)) table
// ----------------------------------------------------------------------------
`default_nettype none

package exp3_pkg;

   // default sizes
   localparam int MAX_ARMS_DEF   = 16;
   localparam int PROB_BITS_DEF  = 24;
   localparam int SCORE_BITS_DEF = 40;

   // fixed field widths
   localparam int GAMMA_W   = 17;
   localparam int NARMS_W   = 5;
   localparam int CSR_IDX_W = 2;
   localparam int EXP_BITS  = 21;
   localparam int E_W       = 25;

   localparam logic [GAMMA_W-1:0] GAMMA_ONE   = 17'd65536;
   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 17'd655;
   localparam logic [NARMS_W-1:0] NARMS_RESET = 5'd16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ARMS = 2'd1;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_CHOOSE = 2'd1,
      ACT_REWARD = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOINIT = 2'd1,
      ST_RANGE  = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_LOAD,
      S_LWAIT,
      S_RINC,
      S_RWAIT,
      S_MAX,
      S_EXP0,
      S_EXP,
      S_EXPW,
      S_UWAIT,
      S_SSTART,
      S_SWAIT,
      S_TOT,
      S_TMUL,
      S_WALK,
      S_OUT
   } state_type;

   // divider handshake
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // exp(-2^(k-16)) in q0.32
   function automatic logic [31:0] exp_bit(input logic [4:0] k);
      logic [31:0] r;
      case (k)
         5'd0:  r = 32'd4294901760;
         5'd1:  r = 32'd4294836226;
         5'd2:  r = 32'd4294705160;
         5'd3:  r = 32'd4294443040;
         5'd4:  r = 32'd4293918848;
         5'd5:  r = 32'd4292870656;
         5'd6:  r = 32'd4290775039;
         5'd7:  r = 32'd4286586875;
         5'd8:  r = 32'd4278222805;
         5'd9:  r = 32'd4261543595;
         5'd10: r = 32'd4228380000;
         5'd11: r = 32'd4162825044;
         5'd12: r = 32'd4034748382;
         5'd13: r = 32'd3790295335;
         5'd14: r = 32'd3344923893;
         5'd15: r = 32'd2605029347;
         5'd16: r = 32'd1580030169;
         5'd17: r = 32'd581260616;
         5'd18: r = 32'd78665070;
         5'd19: r = 32'd1440801;
         5'd20: r = 32'd483;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/exp3_div.sv =====
// ----------------------------------------------------------------------------
// exp3 restoring divider
// unsigned divide, one quotient bit per cycle, operands latched at start
// ----------------------------------------------------------------------------
`default_nettype none

module exp3_div #(
   parameter int NW = 49,
   parameter int DW = 30
) (
   input  wire                      clock,
   input  wire                      reset,
   input  exp3_pkg::div_ctl_type    ctl,
   input  wire  [NW-1:0]            num,
   input  wire  [DW-1:0]            den,
   output exp3_pkg::div_sts_type    sts,
   output logic [NW-1:0]            quo
);
   import exp3_pkg::*;

   localparam int CNT_W = $clog2(NW + 1);

   logic [DW:0]      rem_ff, rem_in;
   logic [NW-1:0]    q_ff, q_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DW:0]      trial;

   // one shift and subtract step, or operand load on start
   always_comb begin
      trial   = {rem_ff[DW-1:0], q_ff[NW-1]};
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in  = '0;
         q_in    = num;
         den_in  = den;
         cnt_in  = CNT_W'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // data
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo      = q_ff;

endmodule

`default_nettype wire

// ===== design/exp3_bandit_arm_selector.sv =====
// ----------------------------------------------------------------------------
// exp3 bandit arm selector
// score per arm, softmax mixed with uniform exploration, arm draw by random word
// ----------------------------------------------------------------------------
// one item at a time; a result beat follows each accepted item
// load: a last load adds one divide, which sets every probability to 1/K
// choose: one walk over the probability registers sums them, a second draws the arm
// reward: dominated by the exp multiply (21 steps per arm) and the shared bit-serial
//   divider (one divide per arm)
// synchronous reset clears scores, probabilities and the ready flag
`default_nettype none

module exp3_bandit_arm_selector #(
   parameter int MAX_ARMS   = exp3_pkg::MAX_ARMS_DEF,
   parameter int PROB_BITS  = exp3_pkg::PROB_BITS_DEF,
   parameter int SCORE_BITS = exp3_pkg::SCORE_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [1:0]                            req_action,
   input  wire  [3:0]                            req_arm,
   input  wire  [15:0]                           req_value,
   input  wire  [23:0]                           req_random_word,
   input  wire                                   req_last,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [4:0]                            rsp_chosen_arm,
   output logic [PROB_BITS:0]                    rsp_arm_probability,
   output logic [1:0]                            rsp_status,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [exp3_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [exp3_pkg::GAMMA_W-1:0]          csr_data
);
   import exp3_pkg::*;

   localparam int IW  = $clog2(MAX_ARMS);
   localparam int PW  = PROB_BITS + 1;
   localparam int SB  = SCORE_BITS;
   localparam int SW  = E_W + IW;
   localparam int NW  = PROB_BITS + E_W;
   localparam int DA  = (PROB_BITS + 6 > SW) ? PROB_BITS + 6 : SW;
   localparam int DW  = (DA > 21) ? DA : 21;
   localparam int TW  = PW + IW;
   localparam int CW  = (NW > SB) ? NW : SB;
   localparam int KW  = (IW > NARMS_W) ? IW : NARMS_W;
   localparam int MW  = GAMMA_W + PW;
   localparam logic [SB-1:0] SCORE_MAX = {1'b0, {(SB-1){1'b1}}};

   // arm state
   logic [SB-1:0]  score_ff [MAX_ARMS];
   logic [PW-1:0]  mixed_ff [MAX_ARMS];
   logic [E_W-1:0] e_ff     [MAX_ARMS];

   state_type      state_ff, state_in;
   logic [GAMMA_W-1:0] gamma_ff;
   logic [NARMS_W-1:0] num_arms_ff;
   logic           ready_ff, ready_in;

   logic [1:0]     action_ff;
   logic [3:0]     arm_ff;
   logic [23:0]    rw_ff;
   logic           last_ff;
   logic [NARMS_W-1:0] k_ff;
   logic [GAMMA_W-1:0] g_ff;
   logic [15:0]    gv_ff;

   logic [IW-1:0]  idx_ff, idx_in;
   logic [SB-1:0]  mx_ff, mx_in;
   logic [SW-1:0]  sum_ff, sum_in;
   logic [PW-1:0]  uni_ff, uni_in;
   logic [TW-1:0]  total_ff, total_in;
   logic [TW-1:0]  t_ff, t_in;
   logic [TW-1:0]  cum_ff, cum_in;
   logic [32:0]    acc_ff, acc_in;
   logic [EXP_BITS-1:0] d_ff, d_in;
   logic           dbig_ff, dbig_in;
   logic [4:0]     kbit_ff, kbit_in;
   logic [1:0]     status_ff, status_in;
   logic [4:0]     chosen_ff, chosen_in;
   logic           pen_ff, pen_in;

   logic           rsp_valid_ff;
   logic [4:0]     rsp_chosen_ff;
   logic [PW-1:0]  rsp_prob_ff;
   logic [1:0]     rsp_status_ff;

   // array write controls
   logic           score_we;
   logic [SB-1:0]  score_wd;
   logic           mixed_we, mixed_bc;
   logic [PW-1:0]  mixed_wd;
   logic           e_we;
   logic [E_W-1:0] e_wd;

   // divider
   div_ctl_type    div_ctl;
   div_sts_type    div_sts;
   logic [NW-1:0]  div_num, div_quo;
   logic [DW-1:0]  div_den;

   // helpers
   logic           accept, rsp_take, out_load;
   logic [SB-1:0]  score_rd;
   logic [PW-1:0]  mixed_rd;
   logic [E_W-1:0] e_rd;
   logic           arm_ok, last_idx;
   logic [IW-1:0]  arm_idx;
   logic [NARMS_W-1:0] k_eff;
   logic [GAMMA_W-1:0] g_eff;
   logic [32:0]    gv_prod;
   logic [64:0]    exp_prod;
   logic [SB-1:0]  d_full, headroom, score_sat;
   logic [MW-1:0]  mix_prod;
   logic [TW+23:0] t_prod;
   logic [TW-1:0]  cum_new;
   logic [SW-1:0]  sum_nz;
   logic [PW+4:0]  ph_k;

   assign accept    = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff    <= GAMMA_RESET;
         num_arms_ff <= NARMS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAMMA:    gamma_ff    <= csr_data;
            CSR_NUM_ARMS: num_arms_ff <= csr_data[NARMS_W-1:0];
            default: ;
         endcase
      end
   end

   // effective arm count and gamma
   always_comb begin
      if (num_arms_ff == '0)
         k_eff = NARMS_W'(1);
      else if (int'(num_arms_ff) > MAX_ARMS)
         k_eff = NARMS_W'(MAX_ARMS);
      else
         k_eff = num_arms_ff;
      g_eff   = (gamma_ff > GAMMA_ONE) ? GAMMA_ONE : gamma_ff;
      gv_prod = 33'(g_eff) * 33'(req_value);
   end

   // reads at the sequencer index
   assign score_rd = score_ff[idx_ff];
   assign mixed_rd = mixed_ff[idx_ff];
   assign e_rd     = e_ff[idx_ff];
   assign arm_idx  = IW'(arm_ff);
   assign arm_ok   = ({1'b0, arm_ff} < k_ff);
   assign last_idx = (KW'(idx_ff) == KW'(k_ff) - KW'(1));

   // arithmetic shared by the steps
   assign exp_prod  = 65'(acc_ff) * 65'(exp_bit(kbit_ff));
   assign d_full    = mx_ff - score_rd;
   assign headroom  = SCORE_MAX - score_rd;
   assign score_sat = (CW'(div_quo) > CW'(headroom)) ? SCORE_MAX
                                                     : score_rd + SB'(div_quo);
   assign mix_prod  = MW'(GAMMA_ONE - g_ff) * MW'(div_quo[PW-1:0]);
   assign t_prod    = (TW+24)'(rw_ff) * (TW+24)'(total_ff);
   assign cum_new   = cum_ff + TW'(mixed_rd);
   assign sum_nz    = (sum_ff == '0) ? SW'(1) : sum_ff;
   assign ph_k      = (PW+5)'(mixed_rd) * (PW+5)'(k_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (accept) state_in = S_DECODE;
         S_DECODE: begin
            case (action_ff)
               ACT_LOAD:   state_in = S_LOAD;
               ACT_CHOOSE: state_in = ready_ff ? S_TOT : S_OUT;
               ACT_REWARD: state_in = (ready_ff && arm_ok) ? S_RINC : S_OUT;
               default:    state_in = S_OUT;
            endcase
         end
         S_LOAD:   state_in = last_ff ? S_LWAIT : S_OUT;
         S_LWAIT:  if (div_sts.done) state_in = S_OUT;
         S_RINC:   state_in = (gv_ff != '0 && mixed_rd != '0) ? S_RWAIT : S_MAX;
         S_RWAIT:  if (div_sts.done) state_in = S_MAX;
         S_MAX:    if (last_idx) state_in = S_EXP0;
         S_EXP0:   state_in = S_EXP;
         S_EXP:    if (kbit_ff == 5'(EXP_BITS - 1)) state_in = S_EXPW;
         S_EXPW:   state_in = last_idx ? S_UWAIT : S_EXP0;
         S_UWAIT:  if (div_sts.done) state_in = S_SSTART;
         S_SSTART: state_in = S_SWAIT;
         S_SWAIT:  if (div_sts.done) state_in = last_idx ? S_OUT : S_SSTART;
         S_TOT:    if (last_idx) state_in = S_TMUL;
         S_TMUL:   state_in = S_WALK;
         S_WALK:   if (t_ff <= cum_new || last_idx) state_in = S_OUT;
         S_OUT:    if (!rsp_valid_ff || rsp_take) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and array controls
   always_comb begin
      idx_in    = idx_ff;
      mx_in     = mx_ff;
      sum_in    = sum_ff;
      uni_in    = uni_ff;
      total_in  = total_ff;
      t_in      = t_ff;
      cum_in    = cum_ff;
      acc_in    = acc_ff;
      d_in      = d_ff;
      dbig_in   = dbig_ff;
      kbit_in   = kbit_ff;
      status_in = status_ff;
      chosen_in = chosen_ff;
      pen_in    = pen_ff;
      ready_in  = ready_ff;
      score_we  = 1'b0;
      score_wd  = score_sat;
      mixed_we  = 1'b0;
      mixed_bc  = 1'b0;
      mixed_wd  = PW'(mix_prod >> 16) + uni_ff;
      e_we      = 1'b0;
      e_wd      = dbig_ff ? '0 : E_W'(acc_ff >> 8);
      div_ctl.start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      out_load  = 1'b0;
      case (state_ff)
         S_DECODE: begin
            status_in = ST_OK;
            chosen_in = '0;
            pen_in    = 1'b0;
            total_in  = '0;
            cum_in    = '0;
            mx_in     = '0;
            idx_in    = arm_idx;
            case (action_ff)
               ACT_CHOOSE: begin
                  idx_in = '0;
                  if (!ready_ff) status_in = ST_NOINIT;
               end
               ACT_REWARD: begin
                  if (!ready_ff) status_in = ST_NOINIT;
                  else if (!arm_ok) status_in = ST_RANGE;
               end
               default: ;
            endcase
         end
         S_LOAD: begin
            if (arm_ok) begin
               score_we = 1'b1;
               score_wd = SB'(gv_ff);
               pen_in   = 1'b1;
            end else begin
               status_in = ST_RANGE;
            end
            if (last_ff) begin
               div_ctl.start = 1'b1;
               div_num = NW'(1) << PROB_BITS;
               div_den = DW'(k_ff);
            end
         end
         S_LWAIT: begin
            if (div_sts.done) begin
               mixed_bc = 1'b1;
               mixed_wd = div_quo[PW-1:0];
               ready_in = 1'b1;
            end
         end
         S_RINC: begin
            pen_in = 1'b1;
            if (gv_ff != '0 && mixed_rd != '0) begin
               div_ctl.start = 1'b1;
               div_num = NW'(gv_ff) << PROB_BITS;
               div_den = DW'(ph_k);
            end else begin
               if (gv_ff != '0) begin
                  score_we = 1'b1;
                  score_wd = SCORE_MAX;
               end
               idx_in = '0;
            end
         end
         S_RWAIT: begin
            if (div_sts.done) begin
               score_we = 1'b1;
               idx_in   = '0;
            end
         end
         S_MAX: begin
            if (score_rd > mx_ff) mx_in = score_rd;
            if (last_idx) begin
               idx_in = '0;
               sum_in = '0;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_EXP0: begin
            d_in    = d_full[EXP_BITS-1:0];
            dbig_in = |(d_full >> EXP_BITS);
            acc_in  = 33'(1) << 32;
            kbit_in = '0;
         end
         S_EXP: begin
            if (d_ff[kbit_ff]) acc_in = exp_prod[64:32];
            kbit_in = kbit_ff + 5'(1);
         end
         S_EXPW: begin
            e_we   = 1'b1;
            sum_in = sum_ff + SW'(e_wd);
            if (last_idx) begin
               idx_in = '0;
               div_ctl.start = 1'b1;
               div_num = NW'(g_ff) << PROB_BITS;
               div_den = DW'(k_ff) << 16;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_UWAIT: begin
            if (div_sts.done) uni_in = div_quo[PW-1:0];
         end
         S_SSTART: begin
            div_ctl.start = 1'b1;
            div_num = NW'(e_rd) << PROB_BITS;
            div_den = DW'(sum_nz);
         end
         S_SWAIT: begin
            if (div_sts.done) begin
               mixed_we = 1'b1;
               idx_in   = last_idx ? arm_idx : idx_ff + IW'(1);
            end
         end
         S_TOT: begin
            total_in = total_ff + TW'(mixed_rd);
            if (last_idx) idx_in = '0;
            else idx_in = idx_ff + IW'(1);
         end
         S_TMUL: begin
            t_in = TW'(t_prod >> 24);
         end
         S_WALK: begin
            cum_in = cum_new;
            if (t_ff <= cum_new) begin
               chosen_in = 5'(idx_ff);
               pen_in    = 1'b1;
            end else if (last_idx) begin
               chosen_in = k_ff;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_take) out_load = 1'b1;
         end
         default: ;
      endcase
   end

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_take) rsp_valid_ff <= 1'b0;
      end
   end

   // item capture and working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         arm_ff    <= req_arm;
         rw_ff     <= req_random_word;
         last_ff   <= req_last;
         k_ff      <= k_eff;
         g_ff      <= g_eff;
         gv_ff     <= gv_prod[31:16];
      end
      idx_ff    <= idx_in;
      mx_ff     <= mx_in;
      sum_ff    <= sum_in;
      uni_ff    <= uni_in;
      total_ff  <= total_in;
      t_ff      <= t_in;
      cum_ff    <= cum_in;
      acc_ff    <= acc_in;
      d_ff      <= d_in;
      dbig_ff   <= dbig_in;
      kbit_ff   <= kbit_in;
      status_ff <= status_in;
      chosen_ff <= chosen_in;
      pen_ff    <= pen_in;
      if (out_load) begin
         rsp_chosen_ff <= chosen_ff;
         rsp_status_ff <= status_ff;
         rsp_prob_ff   <= pen_ff ? mixed_rd : '0;
      end
   end

   // score and probability registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ARMS; i++) begin
            score_ff[i] <= '0;
            mixed_ff[i] <= '0;
         end
      end else begin
         if (score_we) score_ff[idx_ff] <= score_wd;
         if (mixed_bc) begin
            for (int i = 0; i < MAX_ARMS; i++) mixed_ff[i] <= mixed_wd;
         end else if (mixed_we) begin
            mixed_ff[idx_ff] <= mixed_wd;
         end
      end
   end

   // exp terms
   always_ff @(posedge clock) begin
      if (e_we) e_ff[idx_ff] <= e_wd;
   end

   exp3_div #(
      .NW (NW),
      .DW (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (div_den),
      .sts   (div_sts),
      .quo   (div_quo)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_chosen_arm      = rsp_chosen_ff;
   assign rsp_arm_probability = rsp_prob_ff;
   assign rsp_status          = rsp_status_ff;

   // checks
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("second item taken while one is in work");

   a_err_no_prob: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_prob_ff == '0)
      else $error("probability reported on an error beat");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// exp3 bandit arm selector testbench
// drives load, choose, reward and unused-action beats under bursty sender and stalling
// receiver, predicts every result in a bit-accurate model and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import exp3_pkg::*;

   localparam int                   LIMIT_CYCLES = 6_000_000;
   localparam int                   ARMS_TOP     = 16;
   localparam logic [1:0]           ACT_UNUSED   = 2'd3;
   localparam longint unsigned      SCORE_SAT    = (64'd1 << 39) - 64'd1;
   localparam longint unsigned      PROB_UNIT    = 64'd1 << 24;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  arm;
      logic [15:0] value;
      logic [23:0] random_word;
      logic        last;
   } beat_t;

   typedef struct packed {
      logic [4:0]  chosen;
      logic [24:0] prob;
      logic [1:0]  status;
   } outcome_t;

   // exp(-2^(k-16)) in q0.32
   bit [31:0] exp_step_q32 [21] = '{
      32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
      32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
      32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
      32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
      32'd1580030169, 32'd581260616,  32'd78665070,   32'd1440801,
      32'd483};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_LOAD;
   logic [3:0]  req_arm = '0;
   logic [15:0] req_value = '0;
   logic [23:0] req_random_word = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [4:0]  rsp_chosen_arm;
   logic [24:0] rsp_arm_probability;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GAMMA;
   logic [GAMMA_W-1:0]   csr_data = '0;

   // model copy of the block
   bit [16:0] gamma_reg;
   bit [4:0]  arms_reg;
   bit [39:0] arm_score [ARMS_TOP];
   bit [31:0] pulls [ARMS_TOP];
   bit [24:0] soft_prob [ARMS_TOP];
   bit [24:0] mix_prob [ARMS_TOP];
   bit [31:0] reward_steps;
   bit        armed;

   beat_t    pending_beats [$];
   outcome_t expected_outcomes [$];
   int       mismatch_count = 0;
   int       outcomes_seen = 0;
   int       cycle_count = 0;

   exp3_bandit_arm_selector i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_arm(req_arm), .req_value(req_value), .req_random_word(req_random_word),
      .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_chosen_arm(rsp_chosen_arm),
      .rsp_arm_probability(rsp_arm_probability), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data));

   always #5 clock = ~clock;

   function automatic longint unsigned arms_in_use(bit [4:0] n);
      if (n == 0) return 1;
      if (n > ARMS_TOP) return ARMS_TOP;
      return 64'(n);
   endfunction

   // bandit update for one beat, returns the outcome it causes
   function automatic outcome_t bandit_update(beat_t b);
      outcome_t        r;
      longint unsigned k, g, gv, total, cum, t, inc, ph, sc, mx, sum, d, acc, uni;
      longint unsigned ev [ARMS_TOP];
      int              i, j;
      r = '0;
      k = arms_in_use(arms_reg);
      g = (gamma_reg > 17'd65536) ? 64'd65536 : longint'(gamma_reg);
      gv = (g * longint'(b.value)) >> 16;
      case (b.action)
         ACT_LOAD: begin
            if (b.arm < k) arm_score[b.arm] = 40'(gv);
            else r.status = ST_RANGE;
            if (b.last) begin
               for (i = 0; i < ARMS_TOP; i++) begin
                  soft_prob[i] = 25'(PROB_UNIT / k);
                  mix_prob[i] = 25'(PROB_UNIT / k);
                  pulls[i] = 1;
               end
               armed = 1'b1;
            end
            if (r.status == ST_OK) r.prob = mix_prob[b.arm];
         end
         ACT_CHOOSE: begin
            if (!armed) r.status = ST_NOINIT;
            else begin
               total = 0;
               cum = 0;
               for (i = 0; i < k; i++) total += mix_prob[i];
               t = (longint'(b.random_word) * total) >> 24;
               r.chosen = 5'(k);
               for (i = 0; i < k; i++) begin
                  cum += mix_prob[i];
                  if (t <= cum) begin
                     r.chosen = 5'(i);
                     break;
                  end
               end
               if (r.chosen < k) r.prob = mix_prob[r.chosen];
            end
         end
         ACT_REWARD: begin
            if (!armed) r.status = ST_NOINIT;
            else if (b.arm >= k) r.status = ST_RANGE;
            else begin
               ph = mix_prob[b.arm];
               pulls[b.arm]++;
               reward_steps++;
               inc = 0;
               if (gv != 0) inc = (ph == 0) ? SCORE_SAT : (gv << 24) / (ph * k);
               sc = arm_score[b.arm];
               if (sc > SCORE_SAT) sc = SCORE_SAT;
               if (inc > SCORE_SAT - sc) sc = SCORE_SAT;
               else sc += inc;
               arm_score[b.arm] = 40'(sc);
               // softmax over arms in use, then mix with uniform
               mx = 0;
               for (i = 0; i < k; i++) if (arm_score[i] > mx) mx = arm_score[i];
               sum = 0;
               for (i = 0; i < k; i++) begin
                  d = mx - arm_score[i];
                  acc = 64'd1 << 32;
                  if ((d >> 21) != 0) acc = 0;
                  else
                     for (j = 0; j < 21; j++)
                        if (d[j]) acc = (acc * exp_step_q32[j]) >> 32;
                  ev[i] = acc >> 8;
                  sum += ev[i];
               end
               if (sum == 0) sum = 1;
               uni = (g << 24) / (k << 16);
               for (i = 0; i < k; i++) begin
                  soft_prob[i] = 25'((ev[i] << 24) / sum);
                  mix_prob[i] = 25'((((64'd65536 - g) * soft_prob[i]) >> 16) + uni);
               end
               r.prob = mix_prob[b.arm];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // sender: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      beat_t nb;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            expected_outcomes.push_back(bandit_update({req_action, req_arm, req_value,
                                                       req_random_word, req_last}));
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            nb = pending_beats.pop_front();
            {req_action, req_arm, req_value, req_random_word, req_last} <= nb;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(0, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern plus one long hold-off
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int phase_tick = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left <= $urandom_range(16, 128);
      end else begin
         mode_left <= mode_left - 1;
      end
      phase_tick <= phase_tick + 1;
      if (!hold_done && outcomes_seen == 30) begin
         hold_done <= 1'b1;
         hold_left <= 3000;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 6);
            default: rsp_stall <= phase_tick[1];
         endcase
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      outcome_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         outcomes_seen <= outcomes_seen + 1;
         if (expected_outcomes.size() == 0) begin
            $display("%0t: result beat with nothing expected: arm %0d prob %0d status %0d",
                     $time, rsp_chosen_arm, rsp_arm_probability, rsp_status);
            mismatch_count++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_chosen_arm !== want.chosen) begin
               $display("%0t: chosen_arm expected %0d actual %0d",
                        $time, want.chosen, rsp_chosen_arm);
               mismatch_count++;
            end
            if (rsp_arm_probability !== want.prob) begin
               $display("%0t: arm_probability expected %0d actual %0d",
                        $time, want.prob, rsp_arm_probability);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic queue_beat(logic [1:0] act, logic [3:0] arm, logic [15:0] val,
                             logic [23:0] rw, logic last);
      pending_beats.push_back({act, arm, val, rw, last});
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [GAMMA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_GAMMA) gamma_reg = data;
      else if (idx == CSR_NUM_ARMS) arms_reg = data[4:0];
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_beats.size() > 0 || req_valid || expected_outcomes.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic logic [23:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom_range(0, 24'hFFFFFF));
      endcase
   endfunction

   // mostly an init sequence then choose/reward traffic, with some noise
   task automatic queue_random(int count);
      longint unsigned k;
      int              i, sel;
      logic [3:0]      a;
      k = arms_in_use(arms_reg);
      for (i = 0; i < ARMS_TOP; i++)
         queue_beat(ACT_LOAD, 4'(i), pick_value(), 24'($urandom), i == ARMS_TOP - 1);
      for (i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         a = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                            : $urandom_range(0, 32'(k - 1)));
         if (sel < 45)
            queue_beat(ACT_REWARD, a, pick_value(), 24'($urandom), 1'($urandom));
         else if (sel < 85)
            queue_beat(ACT_CHOOSE, 4'($urandom), 16'($urandom), pick_word(),
                       1'($urandom));
         else if (sel < 94)
            queue_beat(ACT_LOAD, a, pick_value(), 24'($urandom), $urandom_range(0, 3) == 0);
         else
            queue_beat(ACT_UNUSED, 4'($urandom), 16'($urandom), 24'($urandom),
                       1'($urandom));
      end
   endtask

   // gamma / num_arms per phase
   int gamma_set [7] = '{655, 65536, 0, 131071, 3000, 40000, 20000};
   int arms_set  [7] = '{16, 1, 4, 0, 31, 7, 16};

   initial begin
      int p;
      gamma_reg = GAMMA_RESET;
      arms_reg = NARMS_RESET;
      foreach (arm_score[i]) begin
         arm_score[i] = '0;
         pulls[i] = '0;
         soft_prob[i] = '0;
         mix_prob[i] = '0;
      end
      reward_steps = '0;
      armed = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < 7; p++) begin
         write_reg(CSR_GAMMA, GAMMA_W'(gamma_set[p]));
         write_reg(CSR_NUM_ARMS, GAMMA_W'(arms_set[p]));
         if (p == 0) begin
            // before init, unused action, extremes, init, then use
            queue_beat(ACT_CHOOSE, 4'd0, 16'd0, 24'hFFFFFF, 1'b0);
            queue_beat(ACT_REWARD, 4'd1, 16'hFFFF, 24'd0, 1'b0);
            queue_beat(ACT_UNUSED, 4'hF, 16'hFFFF, 24'hFFFFFF, 1'b1);
            queue_beat(ACT_LOAD, 4'd0, 16'd0, 24'd0, 1'b0);
            queue_beat(ACT_LOAD, 4'd5, 16'h8000, 24'd0, 1'b0);
            queue_beat(ACT_LOAD, 4'd15, 16'hFFFF, 24'hFFFFFF, 1'b1);
            queue_beat(ACT_CHOOSE, 4'd0, 16'd0, 24'd0, 1'b0);
            queue_beat(ACT_CHOOSE, 4'd0, 16'd0, 24'hFFFFFF, 1'b0);
            queue_beat(ACT_REWARD, 4'd0, 16'hFFFF, 24'd0, 1'b0);
            queue_beat(ACT_REWARD, 4'd15, 16'd0, 24'd0, 1'b0);
            queue_beat(ACT_REWARD, 4'd3, 16'd1, 24'd0, 1'b1);
            queue_beat(ACT_CHOOSE, 4'd0, 16'd0, 24'h800000, 1'b0);
            queue_beat(ACT_UNUSED, 4'd0, 16'd0, 24'd0, 1'b0);
         end else if (p == 2) begin
            // arm index beyond the arms in use
            queue_beat(ACT_REWARD, 4'd9, 16'hFFFF, 24'd0, 1'b0);
            queue_beat(ACT_LOAD, 4'd12, 16'h1234, 24'd0, 1'b0);
            queue_beat(ACT_LOAD, 4'd12, 16'h4321, 24'd0, 1'b1);
            queue_beat(ACT_CHOOSE, 4'd0, 16'd0, 24'hFFFFFF, 1'b0);
         end
         queue_random(125);
         wait_drained();
      end

      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
